@@ rtl/hrhp_pkg.sv @@
`timescale 1ns / 1ps
package hrhp_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Result kinds: byte kinds first, then events
   localparam logic [3:0] K_METHOD      = 4'd0;
   localparam logic [3:0] K_URI         = 4'd1;
   localparam logic [3:0] K_QKEY        = 4'd2;
   localparam logic [3:0] K_QVAL        = 4'd3;
   localparam logic [3:0] K_VERSION     = 4'd4;
   localparam logic [3:0] K_HKEY        = 4'd5;
   localparam logic [3:0] K_HVAL        = 4'd6;
   localparam logic [3:0] E_METHOD_END  = 4'd7;
   localparam logic [3:0] E_URI_END     = 4'd8;
   localparam logic [3:0] E_QCOMMIT     = 4'd9;
   localparam logic [3:0] E_QDISCARD    = 4'd10;
   localparam logic [3:0] E_VERSION_END = 4'd11;
   localparam logic [3:0] E_HCOMMIT     = 4'd12;
   localparam logic [3:0] E_DONE        = 4'd13;
   localparam logic [3:0] E_ERROR       = 4'd14;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [2:0] HTTP_LAST = 3'd4;
   localparam logic [3:0] ROOT_LEN  = 4'd11;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPACE_CHECK = '0;

   typedef enum logic [6:0] {
      PH_METHOD  = 7'b0000001,
      PH_URI     = 7'b0000010,
      PH_QKEY    = 7'b0000100,
      PH_QVAL    = 7'b0001000,
      PH_VERSION = 7'b0010000,
      PH_HKEY    = 7'b0100000,
      PH_HVAL    = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      LIT_NONE = 2'd0,
      LIT_HTTP = 2'd1,
      LIT_LF   = 2'd2,
      LIT_SP   = 2'd3
   } lit_type;

   // Results sent ahead of the final one in a burst
   typedef enum logic [1:0] {
      PRE_NONE  = 2'd0,
      PRE_SLASH = 2'd1,
      PRE_INDEX = 2'd2
   } pre_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic       start_request;
   } req_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   function automatic logic is_lexical(input logic [7:0] c);
      return (c != CH_CR) && (c != CH_LF);
   endfunction

   function automatic logic is_nonblank(input logic [7:0] c);
      return (c != CH_TAB) && (c != CH_SP) && is_lexical(c);
   endfunction

   function automatic logic is_key(input logic [7:0] c);
      return (c != CH_COLON) && is_nonblank(c);
   endfunction

   function automatic logic is_kv(input logic [7:0] c);
      return (c != CH_EQ) && (c != CH_AMP) && is_nonblank(c);
   endfunction

   function automatic logic [7:0] lit_http_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0:    b = 8'h48; // H
         3'd1:    b = 8'h54; // T
         3'd2:    b = 8'h54; // T
         3'd3:    b = 8'h50; // P
         3'd4:    b = 8'h2F; // /
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] root_name_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h2F; // /
         4'd1:    b = 8'h69; // i
         4'd2:    b = 8'h6E; // n
         4'd3:    b = 8'h64; // d
         4'd4:    b = 8'h65; // e
         4'd5:    b = 8'h78; // x
         4'd6:    b = 8'h2E; // .
         4'd7:    b = 8'h68; // h
         4'd8:    b = 8'h74; // t
         4'd9:    b = 8'h6D; // m
         4'd10:   b = 8'h6C; // l
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [3:0] burst_len(input pre_type pre);
      logic [3:0] n;
      case (pre)
         PRE_SLASH: n = 4'd1;
         PRE_INDEX: n = ROOT_LEN;
         default:   n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

@@ rtl/http_request_header_parser_top.sv @@
`timescale 1ns / 1ps
// HTTP request head parser, one request byte per transfer on the req_ channel.
// Each transfer carries data_byte, end_of_stream and start_request; results
// leave on the rsp_ channel as (kind, out_byte, last), last marking the final
// result caused by one input transfer. Many bytes (literals, separators) give
// no result at all.
// An input transfer is registered in the input register, parsed from there and
// its first result is registered in the result register that drives rsp_valid.
// Throughput: one item per cycle, but an item with a result waits while the
// result register is busy. An item gives at most one result, except a URI byte
// following a held leading slash (two results) and the end of a URI of exactly
// "/" (twelve results: "/index.html" then the uri end event); the result
// register's burst counter holds the next item with a result until all are out.
// When the receiver stalls, the result register holds and the input register
// still takes one more transfer; items that give no result keep flowing.
// Reset (synchronous) empties both registers, puts the parser in the method
// phase and turns the colon-space check on. start_request restarts the parser
// without touching that check. The csr_ port holds the check flag at address 0.
module http_request_header_parser_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hrhp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hrhp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hrhp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [hrhp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hrhp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic                strict_ff;
   logic                csr_wr;

   logic                in_vld_ff, in_vld_in;
   hrhp_pkg::req_type   in_ff;

   hrhp_pkg::phase_type ph_ff, ph_in;
   hrhp_pkg::lit_type   lit_ff, lit_in;
   logic [2:0]          pos_ff, pos_in;
   logic                ks_ff, ks_in;
   logic                vs_ff, vs_in;
   logic [1:0]          uls_ff, uls_in;
   logic                rsh_ff, rsh_in;
   logic                aq_ff, aq_in;
   logic                fin_ff, fin_in;

   logic [7:0]          c;
   logic [7:0]          want;
   logic                err;
   logic                emit;
   logic [3:0]          ekind;
   logic [7:0]          ebyte;
   hrhp_pkg::pre_type   epre;

   logic                proc;
   logic                out_free;

   logic                out_vld_ff, out_vld_in;
   hrhp_pkg::pre_type   pre_ff;
   logic [3:0]          fin_kind_ff;
   logic [7:0]          fin_byte_ff;
   logic [3:0]          cnt_ff, cnt_in;
   logic [3:0]          len_w;
   logic                at_last;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_wr && (csr_paddr[2] == hrhp_pkg::CSR_SPACE_CHECK[2])) begin
         strict_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == hrhp_pkg::CSR_SPACE_CHECK[2]) begin
         csr_prdata[0] = strict_ff;
      end
   end

   // Handshake between input register and result register
   assign len_w    = hrhp_pkg::burst_len(pre_ff);
   assign at_last  = (cnt_ff == len_w);
   assign out_free = !out_vld_ff || (rsp_ready && at_last);
   assign proc     = in_vld_ff && (!emit || out_free);
   assign req_ready = !in_vld_ff || proc;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (proc) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // Parser: next state and the result burst for the registered item
   assign c = in_ff.data_byte;

   always_comb begin
      ph_in  = ph_ff;
      lit_in = lit_ff;
      pos_in = pos_ff;
      ks_in  = ks_ff;
      vs_in  = vs_ff;
      uls_in = uls_ff;
      rsh_in = rsh_ff;
      aq_in  = aq_ff;
      fin_in = fin_ff;
      err    = 1'b0;
      emit   = 1'b0;
      ekind  = hrhp_pkg::K_METHOD;
      ebyte  = '0;
      epre   = hrhp_pkg::PRE_NONE;

      if (in_ff.start_request) begin
         ph_in  = hrhp_pkg::PH_METHOD;
         lit_in = hrhp_pkg::LIT_NONE;
         pos_in = '0;
         ks_in  = 1'b0;
         vs_in  = 1'b0;
         uls_in = '0;
         rsh_in = 1'b0;
         aq_in  = 1'b0;
         fin_in = 1'b0;
      end

      case (lit_in)
         hrhp_pkg::LIT_HTTP: want = hrhp_pkg::lit_http_byte(pos_in);
         hrhp_pkg::LIT_LF:   want = hrhp_pkg::CH_LF;
         default:            want = hrhp_pkg::CH_SP;
      endcase

      if (!fin_in) begin
         if (in_ff.end_of_stream) begin
            err = 1'b1;
         end else if (lit_in != hrhp_pkg::LIT_NONE) begin
            if (c != want) begin
               err = 1'b1;
            end else if ((lit_in == hrhp_pkg::LIT_HTTP) && (pos_in < hrhp_pkg::HTTP_LAST)) begin
               pos_in = pos_in + 3'd1;
            end else begin
               if (lit_in == hrhp_pkg::LIT_HTTP) begin
                  if (aq_in) begin
                     emit  = 1'b1;
                     ekind = vs_in ? hrhp_pkg::E_QCOMMIT : hrhp_pkg::E_QDISCARD;
                  end
                  aq_in = 1'b0;
                  ph_in = hrhp_pkg::PH_VERSION;
               end else if (lit_in == hrhp_pkg::LIT_SP) begin
                  ph_in = hrhp_pkg::PH_HVAL;
               end else if (ph_in == hrhp_pkg::PH_VERSION) begin
                  emit  = 1'b1;
                  ekind = hrhp_pkg::E_VERSION_END;
                  ph_in = hrhp_pkg::PH_HKEY;
                  ks_in = 1'b0;
               end else if (ph_in == hrhp_pkg::PH_HKEY) begin
                  emit   = 1'b1;
                  ekind  = hrhp_pkg::E_DONE;
                  fin_in = 1'b1;
               end else begin
                  emit  = 1'b1;
                  ekind = hrhp_pkg::E_HCOMMIT;
                  ph_in = hrhp_pkg::PH_HKEY;
                  ks_in = 1'b0;
               end
               lit_in = hrhp_pkg::LIT_NONE;
               pos_in = '0;
            end
         end else begin
            case (ph_in)
               hrhp_pkg::PH_METHOD: begin
                  if (hrhp_pkg::is_nonblank(c)) begin
                     emit  = 1'b1;
                     ekind = hrhp_pkg::K_METHOD;
                     ebyte = c;
                  end else if (c == hrhp_pkg::CH_SP) begin
                     emit   = 1'b1;
                     ekind  = hrhp_pkg::E_METHOD_END;
                     ph_in  = hrhp_pkg::PH_URI;
                     uls_in = '0;
                     rsh_in = 1'b0;
                  end else begin
                     err = 1'b1;
                  end
               end
               hrhp_pkg::PH_URI: begin
                  if (hrhp_pkg::is_nonblank(c) && (c != hrhp_pkg::CH_QUEST)) begin
                     if ((uls_in == 2'd0) && (c == hrhp_pkg::CH_SLASH)) begin
                        rsh_in = 1'b1;
                        uls_in = 2'd1;
                     end else begin
                        // release a held leading slash ahead of this byte
                        if (rsh_in) begin
                           epre   = hrhp_pkg::PRE_SLASH;
                           rsh_in = 1'b0;
                        end
                        emit   = 1'b1;
                        ekind  = hrhp_pkg::K_URI;
                        ebyte  = c;
                        uls_in = 2'd2;
                     end
                  end else if (c inside {hrhp_pkg::CH_QUEST, hrhp_pkg::CH_SP}) begin
                     if (rsh_in) begin
                        epre   = hrhp_pkg::PRE_INDEX;
                        rsh_in = 1'b0;
                     end
                     emit  = 1'b1;
                     ekind = hrhp_pkg::E_URI_END;
                     if (c == hrhp_pkg::CH_QUEST) begin
                        ph_in = hrhp_pkg::PH_QKEY;
                        ks_in = 1'b0;
                     end else begin
                        aq_in  = 1'b0;
                        lit_in = hrhp_pkg::LIT_HTTP;
                        pos_in = '0;
                     end
                  end else begin
                     err = 1'b1;
                  end
               end
               hrhp_pkg::PH_QKEY: begin
                  if (hrhp_pkg::is_kv(c)) begin
                     emit  = 1'b1;
                     ekind = hrhp_pkg::K_QKEY;
                     ebyte = c;
                     ks_in = 1'b1;
                  end else if ((c == hrhp_pkg::CH_EQ) && ks_in) begin
                     ph_in = hrhp_pkg::PH_QVAL;
                     vs_in = 1'b0;
                  end else begin
                     err = 1'b1;
                  end
               end
               hrhp_pkg::PH_QVAL: begin
                  if (hrhp_pkg::is_kv(c)) begin
                     emit  = 1'b1;
                     ekind = hrhp_pkg::K_QVAL;
                     ebyte = c;
                     vs_in = 1'b1;
                  end else if ((c == hrhp_pkg::CH_AMP) && vs_in) begin
                     emit  = 1'b1;
                     ekind = hrhp_pkg::E_QCOMMIT;
                     ph_in = hrhp_pkg::PH_QKEY;
                     ks_in = 1'b0;
                     vs_in = 1'b0;
                  end else if (c == hrhp_pkg::CH_SP) begin
                     aq_in  = 1'b1;
                     lit_in = hrhp_pkg::LIT_HTTP;
                     pos_in = '0;
                  end else begin
                     err = 1'b1;
                  end
               end
               hrhp_pkg::PH_VERSION: begin
                  if (hrhp_pkg::is_nonblank(c)) begin
                     emit  = 1'b1;
                     ekind = hrhp_pkg::K_VERSION;
                     ebyte = c;
                  end else if (c == hrhp_pkg::CH_CR) begin
                     lit_in = hrhp_pkg::LIT_LF;
                     pos_in = '0;
                  end else begin
                     err = 1'b1;
                  end
               end
               hrhp_pkg::PH_HKEY: begin
                  if (hrhp_pkg::is_key(c)) begin
                     emit  = 1'b1;
                     ekind = hrhp_pkg::K_HKEY;
                     ebyte = c;
                     ks_in = 1'b1;
                  end else if (c == hrhp_pkg::CH_COLON) begin
                     vs_in = 1'b0;
                     if (strict_ff) begin
                        lit_in = hrhp_pkg::LIT_SP;
                        pos_in = '0;
                     end else begin
                        ph_in = hrhp_pkg::PH_HVAL;
                     end
                  end else if ((c == hrhp_pkg::CH_CR) && !ks_in) begin
                     lit_in = hrhp_pkg::LIT_LF;
                     pos_in = '0;
                  end else begin
                     err = 1'b1;
                  end
               end
               hrhp_pkg::PH_HVAL: begin
                  if (hrhp_pkg::is_lexical(c)) begin
                     emit  = 1'b1;
                     ekind = hrhp_pkg::K_HVAL;
                     ebyte = c;
                     vs_in = 1'b1;
                  end else begin
                     lit_in = hrhp_pkg::LIT_LF;
                     pos_in = '0;
                  end
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
      end

      if (err) begin
         emit   = 1'b1;
         ekind  = hrhp_pkg::E_ERROR;
         ebyte  = '0;
         epre   = hrhp_pkg::PRE_NONE;
         fin_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= hrhp_pkg::PH_METHOD;
         lit_ff <= hrhp_pkg::LIT_NONE;
         pos_ff <= '0;
         ks_ff  <= 1'b0;
         vs_ff  <= 1'b0;
         uls_ff <= '0;
         rsh_ff <= 1'b0;
         aq_ff  <= 1'b0;
         fin_ff <= 1'b0;
      end else if (proc) begin
         ph_ff  <= ph_in;
         lit_ff <= lit_in;
         pos_ff <= pos_in;
         ks_ff  <= ks_in;
         vs_ff  <= vs_in;
         uls_ff <= uls_in;
         rsh_ff <= rsh_in;
         aq_ff  <= aq_in;
         fin_ff <= fin_in;
      end
   end

   // Result register with burst counter
   always_comb begin
      out_vld_in = out_vld_ff;
      cnt_in     = cnt_ff;
      if (out_vld_ff && rsp_ready) begin
         if (at_last) begin
            out_vld_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 4'd1;
         end
      end
      if (proc && emit) begin
         out_vld_in = 1'b1;
         cnt_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
         pre_ff     <= hrhp_pkg::PRE_NONE;
      end else begin
         out_vld_ff <= out_vld_in;
         cnt_ff     <= cnt_in;
         if (proc && emit) begin
            pre_ff <= epre;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         fin_kind_ff <= ekind;
         fin_byte_ff <= ebyte;
      end
   end

   always_comb begin
      rsp_valid = out_vld_ff;
      if (at_last) begin
         rsp_data.kind     = fin_kind_ff;
         rsp_data.out_byte = fin_byte_ff;
         rsp_data.last     = 1'b1;
      end else begin
         rsp_data.kind     = hrhp_pkg::K_URI;
         rsp_data.out_byte = (pre_ff == hrhp_pkg::PRE_SLASH) ? hrhp_pkg::CH_SLASH
                                                            : hrhp_pkg::root_name_byte(cnt_ff);
         rsp_data.last     = 1'b0;
      end
   end

   a_burst_in_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (cnt_ff <= len_w))
      else $error("burst counter past burst length");

   a_index_ends_uri: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (pre_ff == hrhp_pkg::PRE_INDEX)) |-> (fin_kind_ff == hrhp_pkg::E_URI_END))
      else $error("root name burst not closed by uri end");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (proc && emit) |=> (out_vld_ff && (cnt_ff == 4'd0)))
      else $error("parsed item with result did not load result register");

   a_http_pos: assert property (@(posedge clock) disable iff (reset)
      (lit_ff == hrhp_pkg::LIT_HTTP) |-> (pos_ff <= hrhp_pkg::HTTP_LAST))
      else $error("literal position beyond HTTP/");

endmodule

@@ tb/tb_http_request_header_parser_top.sv @@
`timescale 1ns / 1ps
module tb_http_request_header_parser_top;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [39:0] HTTP_TAG   = "HTTP/";
   localparam logic [87:0] INDEX_PAGE = "/index.html";

   typedef enum int {CC_TOKEN, CC_URI, CC_QUERY, CC_HKEY, CC_TEXT} char_class_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hrhp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hrhp_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [hrhp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [hrhp_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [hrhp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   http_request_header_parser_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Request bytes waiting to be sent, and the tokens the parser must produce
   hrhp_pkg::req_type tx_bytes[$];
   hrhp_pkg::rsp_type parsed_tokens[$];
   hrhp_pkg::rsp_type item_tokens[$];

   int fail_count = 0;
   int queued_items = 0;
   int token_index = 0;
   int cycle_count = 0;

   // Parser model state
   hrhp_pkg::phase_type parse_state = hrhp_pkg::PH_METHOD;
   hrhp_pkg::lit_type lit = hrhp_pkg::LIT_NONE;
   int lit_pos = 0;
   logic key_seen = 1'b0;
   logic value_seen = 1'b0;
   logic [1:0] uri_len = 2'd0;
   logic slash_held = 1'b0;
   logic in_query = 1'b0;
   logic halted = 1'b0;
   logic strict_on = 1'b1;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   function automatic logic is_text(input logic [7:0] c);
      return c != hrhp_pkg::CH_CR && c != hrhp_pkg::CH_LF;
   endfunction

   function automatic logic is_token(input logic [7:0] c);
      return is_text(c) && c != hrhp_pkg::CH_SP && c != hrhp_pkg::CH_TAB;
   endfunction

   function automatic logic is_hdr_key(input logic [7:0] c);
      return is_token(c) && c != hrhp_pkg::CH_COLON;
   endfunction

   function automatic logic is_pair_char(input logic [7:0] c);
      return is_token(c) && c != hrhp_pkg::CH_EQ && c != hrhp_pkg::CH_AMP;
   endfunction

   function automatic void emit(input logic [3:0] k, input logic [7:0] b);
      hrhp_pkg::rsp_type r;
      r.kind = k;
      r.out_byte = b;
      r.last = 1'b0;
      if (item_tokens.size() < 12) item_tokens = {item_tokens, r};
   endfunction

   function automatic void raise_error();
      emit(hrhp_pkg::E_ERROR, 8'h00);
      halted = 1'b1;
   endfunction

   function automatic void restart_parse();
      parse_state = hrhp_pkg::PH_METHOD;
      lit = hrhp_pkg::LIT_NONE;
      lit_pos = 0;
      key_seen = 1'b0;
      value_seen = 1'b0;
      uri_len = 2'd0;
      slash_held = 1'b0;
      in_query = 1'b0;
      halted = 1'b0;
   endfunction

   function automatic void open_literal(input hrhp_pkg::lit_type which);
      lit = which;
      lit_pos = 0;
   endfunction

   // A bare "/" URI expands to the index page
   function automatic void close_uri();
      if (slash_held) begin
         for (int i = 0; i < 11; i++) emit(hrhp_pkg::K_URI, INDEX_PAGE[8*(10-i) +: 8]);
         slash_held = 1'b0;
      end
      emit(hrhp_pkg::E_URI_END, 8'h00);
   endfunction

   function automatic void match_literal(input logic [7:0] c);
      logic [7:0] want;
      case (lit)
         hrhp_pkg::LIT_HTTP: want = HTTP_TAG[8*(4-lit_pos) +: 8];
         hrhp_pkg::LIT_LF:   want = hrhp_pkg::CH_LF;
         default:            want = hrhp_pkg::CH_SP;
      endcase
      if (c != want) begin
         raise_error();
         return;
      end
      if (lit == hrhp_pkg::LIT_HTTP && lit_pos < 4) begin
         lit_pos++;
         return;
      end
      if (lit == hrhp_pkg::LIT_HTTP) begin
         if (in_query) emit(value_seen ? hrhp_pkg::E_QCOMMIT : hrhp_pkg::E_QDISCARD, 8'h00);
         in_query = 1'b0;
         parse_state = hrhp_pkg::PH_VERSION;
      end else if (lit == hrhp_pkg::LIT_SP) begin
         parse_state = hrhp_pkg::PH_HVAL;
      end else if (parse_state == hrhp_pkg::PH_VERSION) begin
         emit(hrhp_pkg::E_VERSION_END, 8'h00);
         parse_state = hrhp_pkg::PH_HKEY;
         key_seen = 1'b0;
      end else if (parse_state == hrhp_pkg::PH_HKEY) begin
         emit(hrhp_pkg::E_DONE, 8'h00);
         halted = 1'b1;
      end else begin
         emit(hrhp_pkg::E_HCOMMIT, 8'h00);
         parse_state = hrhp_pkg::PH_HKEY;
         key_seen = 1'b0;
      end
      lit = hrhp_pkg::LIT_NONE;
      lit_pos = 0;
   endfunction

   function automatic void parse_content(input logic [7:0] c);
      case (parse_state)
         hrhp_pkg::PH_METHOD: begin
            if (is_token(c)) emit(hrhp_pkg::K_METHOD, c);
            else if (c == hrhp_pkg::CH_SP) begin
               emit(hrhp_pkg::E_METHOD_END, 8'h00);
               parse_state = hrhp_pkg::PH_URI;
               uri_len = 2'd0;
               slash_held = 1'b0;
            end else raise_error();
         end
         hrhp_pkg::PH_URI: begin
            if (is_token(c) && c != hrhp_pkg::CH_QUEST) begin
               if (uri_len == 2'd0 && c == hrhp_pkg::CH_SLASH) begin
                  slash_held = 1'b1;
                  uri_len = 2'd1;
               end else begin
                  if (slash_held) begin
                     emit(hrhp_pkg::K_URI, hrhp_pkg::CH_SLASH);
                     slash_held = 1'b0;
                  end
                  emit(hrhp_pkg::K_URI, c);
                  uri_len = 2'd2;
               end
            end else if (c == hrhp_pkg::CH_QUEST) begin
               close_uri();
               parse_state = hrhp_pkg::PH_QKEY;
               key_seen = 1'b0;
            end else if (c == hrhp_pkg::CH_SP) begin
               close_uri();
               in_query = 1'b0;
               open_literal(hrhp_pkg::LIT_HTTP);
            end else raise_error();
         end
         hrhp_pkg::PH_QKEY: begin
            if (is_pair_char(c)) begin
               emit(hrhp_pkg::K_QKEY, c);
               key_seen = 1'b1;
            end else if (c == hrhp_pkg::CH_EQ && key_seen) begin
               parse_state = hrhp_pkg::PH_QVAL;
               value_seen = 1'b0;
            end else raise_error();
         end
         hrhp_pkg::PH_QVAL: begin
            if (is_pair_char(c)) begin
               emit(hrhp_pkg::K_QVAL, c);
               value_seen = 1'b1;
            end else if (c == hrhp_pkg::CH_AMP && value_seen) begin
               emit(hrhp_pkg::E_QCOMMIT, 8'h00);
               parse_state = hrhp_pkg::PH_QKEY;
               key_seen = 1'b0;
               value_seen = 1'b0;
            end else if (c == hrhp_pkg::CH_SP) begin
               in_query = 1'b1;
               open_literal(hrhp_pkg::LIT_HTTP);
            end else raise_error();
         end
         hrhp_pkg::PH_VERSION: begin
            if (is_token(c)) emit(hrhp_pkg::K_VERSION, c);
            else if (c == hrhp_pkg::CH_CR) open_literal(hrhp_pkg::LIT_LF);
            else raise_error();
         end
         hrhp_pkg::PH_HKEY: begin
            if (is_hdr_key(c)) begin
               emit(hrhp_pkg::K_HKEY, c);
               key_seen = 1'b1;
            end else if (c == hrhp_pkg::CH_COLON) begin
               value_seen = 1'b0;
               if (strict_on) open_literal(hrhp_pkg::LIT_SP);
               else parse_state = hrhp_pkg::PH_HVAL;
            end else if (c == hrhp_pkg::CH_CR && !key_seen) open_literal(hrhp_pkg::LIT_LF);
            else raise_error();
         end
         hrhp_pkg::PH_HVAL: begin
            if (is_text(c)) begin
               emit(hrhp_pkg::K_HVAL, c);
               value_seen = 1'b1;
            end else open_literal(hrhp_pkg::LIT_LF);
         end
         default: raise_error();
      endcase
   endfunction

   function automatic void parse_item(input hrhp_pkg::req_type it);
      item_tokens.delete();
      if (it.start_request) restart_parse();
      if (!halted) begin
         if (it.end_of_stream) raise_error();
         else if (lit != hrhp_pkg::LIT_NONE) match_literal(it.data_byte);
         else parse_content(it.data_byte);
      end
      if (item_tokens.size() > 0) item_tokens[item_tokens.size()-1].last = 1'b1;
      parsed_tokens = {parsed_tokens, item_tokens};
   endfunction

   // Sender: gaps mostly short, a few long, with runs of back-to-back transfers
   int send_gap = 0;
   int quiet_run = 0;

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) quiet_run = $urandom_range(30, 80);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_parse();
         strict_on = 1'b1;
         send_gap = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_item(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= tx_bytes.pop_front();
               send_gap = next_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compare each result transfer with the oldest predicted token
   always @(posedge clock) begin : receiver
      hrhp_pkg::rsp_type want;
      int r;
      int hold_left;
      if (reset) begin
         hold_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parsed_tokens.size() == 0) begin
               note_failure($sformatf("result %0d unexpected: kind %0d byte %02h last %0b",
                  token_index, rsp_data.kind, rsp_data.out_byte, rsp_data.last));
            end else begin
               want = parsed_tokens.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                   rsp_data.last !== want.last)
                  note_failure($sformatf(
                     "result %0d: kind %0d/%0d byte %02h/%02h last %0b/%0b (want/got)",
                     token_index, want.kind, rsp_data.kind, want.out_byte,
                     rsp_data.out_byte, want.last, rsp_data.last));
            end
            token_index++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 10) hold_left = $urandom_range(1, 3);
            else if (r < 13) hold_left = $urandom_range(8, 30);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic char_fits(input char_class_type cls, input logic [7:0] c);
      case (cls)
         CC_TOKEN: return is_token(c);
         CC_URI:   return is_token(c) && c != hrhp_pkg::CH_QUEST;
         CC_QUERY: return is_pair_char(c);
         CC_HKEY:  return is_hdr_key(c);
         default:  return is_text(c);
      endcase
   endfunction

   function automatic logic [7:0] rand_char(input char_class_type cls);
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
         else c = 8'($urandom_range(32, 126));
      end while (!char_fits(cls, c));
      return c;
   endfunction

   function automatic void queue_item(input logic [7:0] b, input logic eos, input logic st);
      hrhp_pkg::req_type it;
      it.data_byte = b;
      it.end_of_stream = eos;
      it.start_request = st;
      tx_bytes = {tx_bytes, it};
      queued_items++;
   endfunction

   // Mostly well-formed random request head; now and then cut short by a bad byte
   task automatic queue_request();
      logic [7:0] s[$];
      int n, pairs, hdrs, cut, r;
      logic with_space;
      with_space = strict_on;
      if ($urandom_range(0, 9) == 0) with_space = !with_space;
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      repeat (n) s = {s, rand_char(CC_TOKEN)};
      s = {s, hrhp_pkg::CH_SP};
      r = $urandom_range(0, 9);
      if (r <= 2) s = {s, hrhp_pkg::CH_SLASH};
      else if (r <= 5) begin
         s = {s, hrhp_pkg::CH_SLASH};
         repeat ($urandom_range(1, 4)) s = {s, rand_char(CC_URI)};
      end else if (r <= 8) begin
         repeat ($urandom_range(1, 5)) s = {s, rand_char(CC_URI)};
      end
      if ($urandom_range(0, 2) == 0) begin
         s = {s, hrhp_pkg::CH_QUEST};
         pairs = $urandom_range(1, 3);
         for (int p = 0; p < pairs; p++) begin
            repeat ($urandom_range(1, 3)) s = {s, rand_char(CC_QUERY)};
            s = {s, hrhp_pkg::CH_EQ};
            n = (p == pairs - 1 && $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
            repeat (n) s = {s, rand_char(CC_QUERY)};
            if (p < pairs - 1) s = {s, hrhp_pkg::CH_AMP};
         end
      end
      s = {s, hrhp_pkg::CH_SP};
      for (int i = 0; i < 5; i++) s = {s, HTTP_TAG[8*(4-i) +: 8]};
      repeat ($urandom_range(1, 3)) s = {s, rand_char(CC_TOKEN)};
      s = {s, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
      hdrs = $urandom_range(0, 3);
      repeat (hdrs) begin
         n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         repeat (n) s = {s, rand_char(CC_HKEY)};
         s = {s, hrhp_pkg::CH_COLON};
         if (with_space) s = {s, hrhp_pkg::CH_SP};
         repeat ($urandom_range(0, 5)) s = {s, rand_char(CC_TEXT)};
         if ($urandom_range(0, 4) == 0) s = {s, hrhp_pkg::CH_LF};
         else s = {s, hrhp_pkg::CH_CR};
         s = {s, hrhp_pkg::CH_LF};
      end
      s = {s, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, s.size() - 1) : -1;
      foreach (s[i]) begin
         if (i == cut) begin
            if ($urandom_range(0, 3) == 0)
               queue_item(8'($urandom_range(0, 255)), 1'b1, i == 0);
            else
               queue_item(8'($urandom_range(0, 255)), 1'b0, i == 0);
            break;
         end
         queue_item(s[i], 1'b0, i == 0);
      end
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(3, 10))
         queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 3) == 0);
   endtask

   task automatic run_random(input int count);
      int goal;
      goal = queued_items + count;
      while (queued_items < goal) begin
         if ($urandom_range(0, 9) == 0) queue_noise();
         else queue_request();
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3))
               queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         while (tx_bytes.size() > 4) @(negedge clock);
      end
   endtask

   // Hold until every transfer is out and the pipeline has emptied
   task automatic wait_quiet();
      while (tx_bytes.size() != 0 || req_valid || parsed_tokens.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_transfer(input logic wr, input logic [hrhp_pkg::CSR_DATA_W-1:0] wdata,
                               output logic [hrhp_pkg::CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= hrhp_pkg::CSR_SPACE_CHECK;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(posedge clock);
      if (wr) strict_on = wdata[0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_strict(input logic v);
      logic [hrhp_pkg::CSR_DATA_W-1:0] rd;
      csr_transfer(1'b0, '0, rd);
      if (rd !== {{(hrhp_pkg::CSR_DATA_W-1){1'b0}}, v})
         note_failure($sformatf("colon-space flag read back %0h, want %0b", rd, v));
   endtask

   task automatic set_strict(input logic v);
      logic [hrhp_pkg::CSR_DATA_W-1:0] rd;
      wait_quiet();
      csr_transfer(1'b1, {{(hrhp_pkg::CSR_DATA_W-1){1'b0}}, v}, rd);
      check_strict(v);
   endtask

   initial begin
      logic [7:0] head[] = '{8'hFF, 8'h00, hrhp_pkg::CH_SP, hrhp_pkg::CH_SLASH,
                             hrhp_pkg::CH_SP, "H", "T", "T", "P", "/", "1",
                             hrhp_pkg::CH_CR, hrhp_pkg::CH_LF, "K", hrhp_pkg::CH_COLON,
                             hrhp_pkg::CH_SP, "v", hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                             hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      check_strict(1'b1);

      // Root URI, extreme method bytes, one header, then a byte after completion
      // and an end of stream on a fresh start
      @(negedge clock);
      foreach (head[i]) queue_item(head[i], 1'b0, i == 0);
      queue_item("x", 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1);

      set_strict(1'b0);
      run_random(100);
      set_strict(1'b1);
      run_random(95);
      set_strict(1'b0);
      run_random(95);

      wait_quiet();
      if (parsed_tokens.size() != 0)
         note_failure($sformatf("%0d results never arrived", parsed_tokens.size()));
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/hrhp_pkg.sv
rtl/http_request_header_parser_top.sv
tb/tb_http_request_header_parser_top.sv
